/* rtl/twpi_pkg.sv */
// Shared widths, register reset values and the gain bundle of the wheel speed loop.
package twpi_pkg;

    localparam int SPEED_W = 12;
    localparam int GOAL_W  = 16;
    localparam int ERR_W   = 17;
    localparam int ACC_W   = 14;
    localparam int DUTY_W  = 13;
    localparam int GAIN_W  = 8;
    localparam int LIMIT_W = 13;
    localparam int VOLT_W  = 16;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 8'd10;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 8'd10;
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 13'd6500;
    localparam logic [VOLT_W-1:0]  LOW_VOLTAGE_RST  = 16'd2000;

    // Register word indexes; byte address is 4 * index
    typedef enum logic [1:0] {
        REG_PROP_GAIN    = 2'd0,
        REG_INTEG_GAIN   = 2'd1,
        REG_OUTPUT_LIMIT = 2'd2,
        REG_LOW_VOLTAGE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [LIMIT_W-1:0] output_limit;
    } twpi_gains_t;

endpackage

/* rtl/three_wheel_incremental_pi_speed_loop.sv */
// Top level: three-wheel incremental PI speed loop with APB register port.
// Flow: an input transfer loads the input register, and the result register loads from it on
//   advance, which waits while a held result is stalled; then the result can transfer.
// Throughput: one control tick per cycle unless out_stall holds a result; the arithmetic is
//   one pass from input to result register, and the accumulators update on that same edge.
// Reset: rst_n (async, active low) clears valid flags, accumulators, prior errors; loads defaults.
module three_wheel_incremental_pi_speed_loop
    import twpi_pkg::*;
#(
    parameter int ACCUM_LIMIT = 7200
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // APB register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,

    // Control tick input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [SPEED_W-1:0] speed_a,
    input  logic signed [SPEED_W-1:0] speed_b,
    input  logic signed [SPEED_W-1:0] speed_c,
    input  logic signed [GOAL_W-1:0]  goal_a,
    input  logic signed [GOAL_W-1:0]  goal_b,
    input  logic signed [GOAL_W-1:0]  goal_c,
    input  logic [VOLT_W-1:0]         battery_level,
    input  logic                      drive_enable,

    // Drive result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [DUTY_W-1:0]         duty_a,
    output logic                      reverse_a,
    output logic [DUTY_W-1:0]         duty_b,
    output logic                      reverse_b,
    output logic [DUTY_W-1:0]         duty_c,
    output logic                      reverse_c,
    output logic                      shutdown
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase; the word
    // index is paddr[3:2] and the byte offset bits are ignored.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integ_gain_reg;
    logic [LIMIT_W-1:0] output_limit_reg;
    logic [VOLT_W-1:0]  low_voltage_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_sel;
    twpi_gains_t        gains;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= PROP_GAIN_RST;
            integ_gain_reg   <= INTEG_GAIN_RST;
            output_limit_reg <= OUTPUT_LIMIT_RST;
            low_voltage_reg  <= LOW_VOLTAGE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_PROP_GAIN:    prop_gain_reg    <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:   integ_gain_reg   <= pwdata[GAIN_W-1:0];
                REG_OUTPUT_LIMIT: output_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_LOW_VOLTAGE:  low_voltage_reg  <= pwdata[VOLT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_PROP_GAIN:    prdata = 32'(prop_gain_reg);
            REG_INTEG_GAIN:   prdata = 32'(integ_gain_reg);
            REG_OUTPUT_LIMIT: prdata = 32'(output_limit_reg);
            REG_LOW_VOLTAGE:  prdata = 32'(low_voltage_reg);
            default:          prdata = '0;
        endcase
    end

    assign gains.prop_gain    = prop_gain_reg;
    assign gains.integ_gain   = integ_gain_reg;
    assign gains.output_limit = output_limit_reg;

    // ------------------------------------------------------------------
    // Input register. A tick moves on into the result register whenever
    // that register is empty or its content is being taken, so the input
    // side only stalls while a held tick cannot advance.
    // ------------------------------------------------------------------
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic signed [SPEED_W-1:0] speed_a_reg;
    logic signed [SPEED_W-1:0] speed_b_reg;
    logic signed [SPEED_W-1:0] speed_c_reg;
    logic signed [GOAL_W-1:0]  goal_a_reg;
    logic signed [GOAL_W-1:0]  goal_b_reg;
    logic signed [GOAL_W-1:0]  goal_c_reg;
    logic [VOLT_W-1:0]         battery_level_reg;
    logic                      drive_enable_reg;
    logic                      in_xfer;
    logic                      advance;

    logic                      out_valid_reg;
    logic                      out_valid_next;

    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~advance;
    assign in_xfer  = in_valid & ~in_stall;

    always_comb
    begin
        priority if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload holds no reset; it only loads on a transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            speed_a_reg       <= speed_a;
            speed_b_reg       <= speed_b;
            speed_c_reg       <= speed_c;
            goal_a_reg        <= goal_a;
            goal_b_reg        <= goal_b;
            goal_c_reg        <= goal_c;
            battery_level_reg <= battery_level;
            drive_enable_reg  <= drive_enable;
        end
    end

    // ------------------------------------------------------------------
    // Shutdown check and the three wheel loops. On shutdown the wheels
    // hold their state and the result shows zero drive. Battery equal to
    // the threshold still counts as normal operation.
    // ------------------------------------------------------------------
    logic              stop;
    logic              wheel_update;
    logic [DUTY_W-1:0] duty_a_w;
    logic [DUTY_W-1:0] duty_b_w;
    logic [DUTY_W-1:0] duty_c_w;
    logic              reverse_a_w;
    logic              reverse_b_w;
    logic              reverse_c_w;

    assign stop         = (battery_level_reg < low_voltage_reg) | ~drive_enable_reg;
    assign wheel_update = advance & ~stop;

    twpi_wheel #(
        .ACCUM_LIMIT (ACCUM_LIMIT)
    ) u_wheel_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .gains   (gains),
        .speed   (speed_a_reg),
        .goal    (goal_a_reg),
        .update  (wheel_update),
        .duty    (duty_a_w),
        .reverse (reverse_a_w)
    );

    twpi_wheel #(
        .ACCUM_LIMIT (ACCUM_LIMIT)
    ) u_wheel_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .gains   (gains),
        .speed   (speed_b_reg),
        .goal    (goal_b_reg),
        .update  (wheel_update),
        .duty    (duty_b_w),
        .reverse (reverse_b_w)
    );

    twpi_wheel #(
        .ACCUM_LIMIT (ACCUM_LIMIT)
    ) u_wheel_c (
        .clk     (clk),
        .rst_n   (rst_n),
        .gains   (gains),
        .speed   (speed_c_reg),
        .goal    (goal_c_reg),
        .update  (wheel_update),
        .duty    (duty_c_w),
        .reverse (reverse_c_w)
    );

    // ------------------------------------------------------------------
    // Result register. Hold while stalled, load on advance, drop after
    // the transfer completes.
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] duty_a_reg;
    logic [DUTY_W-1:0] duty_b_reg;
    logic [DUTY_W-1:0] duty_c_reg;
    logic              reverse_a_reg;
    logic              reverse_b_reg;
    logic              reverse_c_reg;
    logic              shutdown_reg;

    always_comb
    begin
        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            duty_a_reg    <= stop ? '0 : duty_a_w;
            duty_b_reg    <= stop ? '0 : duty_b_w;
            duty_c_reg    <= stop ? '0 : duty_c_w;
            reverse_a_reg <= ~stop & reverse_a_w;
            reverse_b_reg <= ~stop & reverse_b_w;
            reverse_c_reg <= ~stop & reverse_c_w;
            shutdown_reg  <= stop;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty_a    = duty_a_reg;
    assign duty_b    = duty_b_reg;
    assign duty_c    = duty_c_reg;
    assign reverse_a = reverse_a_reg;
    assign reverse_b = reverse_b_reg;
    assign reverse_c = reverse_c_reg;
    assign shutdown  = shutdown_reg;

endmodule

/* rtl/twpi_wheel.sv */
// One wheel of the incremental PI loop: error, accumulator update, output clamp.
module twpi_wheel
    import twpi_pkg::*;
#(
    parameter int ACCUM_LIMIT = 7200
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  twpi_gains_t               gains,
    input  logic signed [SPEED_W-1:0] speed,
    input  logic signed [GOAL_W-1:0]  goal,
    input  logic                      update,
    output logic [DUTY_W-1:0]         duty,
    output logic                      reverse
);

    localparam int P_W   = GAIN_W + 1 + ERR_W + 1;
    localparam int I_W   = GAIN_W + 1 + ERR_W;
    localparam int SUM_W = P_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(ACCUM_LIMIT);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI;

    logic signed [ACC_W-1:0]  accum_reg;
    logic signed [ACC_W-1:0]  accum_next;
    logic signed [ERR_W-1:0]  prior_error_reg;

    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W:0]    diff;
    logic signed [GAIN_W:0]   p_gain_s;
    logic signed [GAIN_W:0]   i_gain_s;
    logic signed [P_W-1:0]    p_term;
    logic signed [I_W-1:0]    i_term;
    logic signed [SUM_W-1:0]  sum;
    logic signed [ACC_W:0]    lim;
    logic signed [ACC_W:0]    acc_ext;
    logic signed [ACC_W:0]    drive;
    logic signed [ACC_W:0]    drive_neg;

    assign err      = ERR_W'(speed) - ERR_W'(goal);
    assign diff     = (ERR_W+1)'(err) - (ERR_W+1)'(prior_error_reg);
    assign p_gain_s = $signed({1'b0, gains.prop_gain});
    assign i_gain_s = $signed({1'b0, gains.integ_gain});
    assign p_term   = p_gain_s * diff;
    assign i_term   = i_gain_s * err;
    assign sum      = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(accum_reg);

    // Saturate the accumulator to the symmetric limit.
    always_comb
    begin
        priority if (sum > SAT_HI)
        begin
            accum_next = SAT_HI[ACC_W-1:0];
        end
        else if (sum < SAT_LO)
        begin
            accum_next = SAT_LO[ACC_W-1:0];
        end
        else
        begin
            accum_next = sum[ACC_W-1:0];
        end
    end

    // Clamp the drive to the output limit; the accumulator keeps its own value.
    assign lim     = $signed({2'b00, gains.output_limit});
    assign acc_ext = (ACC_W+1)'(accum_next);

    always_comb
    begin
        priority if (acc_ext > lim)
        begin
            drive = lim;
        end
        else if (acc_ext < -lim)
        begin
            drive = -lim;
        end
        else
        begin
            drive = acc_ext;
        end
    end

    assign drive_neg = -drive;
    assign reverse   = drive[ACC_W];
    assign duty      = drive[ACC_W] ? drive_neg[DUTY_W-1:0] : drive[DUTY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg       <= '0;
            prior_error_reg <= '0;
        end
        else if (update)
        begin
            accum_reg       <= accum_next;
            prior_error_reg <= err;
        end
    end

endmodule

/* dv/tb_three_wheel_incremental_pi_speed_loop.sv */
// Self-checking testbench for the three-wheel incremental PI speed loop.
`timescale 1ns / 100ps

module tb_three_wheel_incremental_pi_speed_loop;
    import twpi_pkg::*;

    localparam int ACCUM_LIMIT      = 7200;
    localparam int DRAIN_CYCLES     = 6;     // margin to drain the input and result registers
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;

    // One control tick; index 0 is wheel A, 1 is B, 2 is C
    typedef struct packed {
        logic [2:0][SPEED_W-1:0] speed;
        logic [2:0][GOAL_W-1:0]  goal;
        logic [VOLT_W-1:0]       battery;
        logic                    enable;
    } tick_t;

    // One drive result, same wheel order
    typedef struct packed {
        logic [2:0][DUTY_W-1:0] duty;
        logic [2:0]             reverse;
        logic                   shutdown;
    } drive_t;

    logic clk;
    logic rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic signed [SPEED_W-1:0] speed_a       = '0;
    logic signed [SPEED_W-1:0] speed_b       = '0;
    logic signed [SPEED_W-1:0] speed_c       = '0;
    logic signed [GOAL_W-1:0]  goal_a        = '0;
    logic signed [GOAL_W-1:0]  goal_b        = '0;
    logic signed [GOAL_W-1:0]  goal_c        = '0;
    logic [VOLT_W-1:0]         battery_level = '0;
    logic                      drive_enable  = 1'b0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DUTY_W-1:0] duty_a;
    logic              reverse_a;
    logic [DUTY_W-1:0] duty_b;
    logic              reverse_b;
    logic [DUTY_W-1:0] duty_c;
    logic              reverse_c;
    logic              shutdown;

    // Pending ticks waiting for a transfer, and drive results still owed by the block
    tick_t  tick_pending[$];
    drive_t drive_expected[$];

    // Shadow copy of the registers and of the per-wheel loop state
    logic [GAIN_W-1:0]  cfg_prop  = PROP_GAIN_RST;
    logic [GAIN_W-1:0]  cfg_integ = INTEG_GAIN_RST;
    logic [LIMIT_W-1:0] cfg_limit = OUTPUT_LIMIT_RST;
    logic [VOLT_W-1:0]  cfg_lowv  = LOW_VOLTAGE_RST;
    int wheel_accum[3]    = '{0, 0, 0};
    int wheel_prev_err[3] = '{0, 0, 0};

    // Idling knobs, percent of cycles; set by the sequence, read by driver and monitor
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  long_hold_req  = 1'b0;
    int  hold_count     = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;

    string wheel_tag[3] = '{"a", "b", "c"};

    three_wheel_incremental_pi_speed_loop #(
        .ACCUM_LIMIT(ACCUM_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .speed_a      (speed_a),
        .speed_b      (speed_b),
        .speed_c      (speed_c),
        .goal_a       (goal_a),
        .goal_b       (goal_b),
        .goal_c       (goal_c),
        .battery_level(battery_level),
        .drive_enable (drive_enable),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .duty_a       (duty_a),
        .reverse_a    (reverse_a),
        .duty_b       (duty_b),
        .reverse_b    (reverse_b),
        .duty_c       (duty_c),
        .reverse_c    (reverse_c),
        .shutdown     (shutdown)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the three wheel loops by one tick and return the drive they produce.
    // Shutdown leaves the loop state untouched.
    function automatic drive_t advance_wheels(input tick_t t);
        drive_t r;
        int err;
        int acc;
        int lim;
        int pg;
        int ig;
        int d;
        r = '0;
        if (t.battery < cfg_lowv || !t.enable)
        begin
            r.shutdown = 1'b1;
            return r;
        end
        pg  = int'(cfg_prop);
        ig  = int'(cfg_integ);
        lim = int'(cfg_limit);
        for (int k = 0; k < 3; k++)
        begin
            err = int'($signed(t.speed[k])) - int'($signed(t.goal[k]));
            acc = wheel_accum[k] + pg * (err - wheel_prev_err[k]) + ig * err;
            // saturate the accumulator itself
            if (acc > ACCUM_LIMIT)
                acc = ACCUM_LIMIT;
            if (acc < -ACCUM_LIMIT)
                acc = -ACCUM_LIMIT;
            wheel_accum[k]    = acc;
            wheel_prev_err[k] = err;
            // clamp only the drive, never the accumulator
            d = acc;
            if (d > lim)
                d = lim;
            if (d < -lim)
                d = -lim;
            r.reverse[k] = (d < 0);
            r.duty[k]    = DUTY_W'((d < 0) ? -d : d);
        end
        return r;
    endfunction

    function automatic tick_t make_tick(input int sa, input int sb, input int sc,
                                        input int ga, input int gb, input int gc,
                                        input int batt, input int en);
        tick_t t;
        t.speed[0] = sa[SPEED_W-1:0];
        t.speed[1] = sb[SPEED_W-1:0];
        t.speed[2] = sc[SPEED_W-1:0];
        t.goal[0]  = ga[GOAL_W-1:0];
        t.goal[1]  = gb[GOAL_W-1:0];
        t.goal[2]  = gc[GOAL_W-1:0];
        t.battery  = batt[VOLT_W-1:0];
        t.enable   = en[0];
        return t;
    endfunction

    // Mostly goals close to the measured speed so the accumulators wander through
    // their whole range instead of sitting at the rails; some far goals, some
    // full-range goals, and a few low-battery or disabled ticks.
    function automatic tick_t random_tick();
        tick_t t;
        int sp;
        int g;
        int pick;
        for (int k = 0; k < 3; k++)
        begin
            sp   = int'($urandom_range(4095)) - 2048;
            pick = $urandom_range(9);
            if (pick < 6)
                g = sp + int'($urandom_range(40)) - 20;
            else if (pick < 8)
                g = int'($urandom_range(8191)) - 4096;
            else
                g = int'($urandom_range(65535)) - 32768;
            t.speed[k] = sp[SPEED_W-1:0];
            t.goal[k]  = g[GOAL_W-1:0];
        end
        pick = $urandom_range(19);
        if (pick < 15)
            t.battery = VOLT_W'($urandom_range(16'hFFFF, cfg_lowv));
        else if (pick < 17)
            t.battery = cfg_lowv;
        else
            t.battery = VOLT_W'($urandom_range(16'hFFFF));
        t.enable = ($urandom_range(19) != 0);
        return t;
    endfunction

    // APB write: a setup cycle, then an access cycle in which the register takes pwdata.
    // Fill the bits above the register width with noise; the block must drop them.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            REG_PROP_GAIN:    mask = 32'h0000_00FF;
            REG_INTEG_GAIN:   mask = 32'h0000_00FF;
            REG_OUTPUT_LIMIT: mask = 32'h0000_1FFF;
            default:          mask = 32'h0000_FFFF;
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~mask) | (value & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP_GAIN:    cfg_prop  = value[GAIN_W-1:0];
            REG_INTEG_GAIN:   cfg_integ = value[GAIN_W-1:0];
            REG_OUTPUT_LIMIT: cfg_limit = value[LIMIT_W-1:0];
            default:          cfg_lowv  = value[VOLT_W-1:0];
        endcase
    endtask

    // Hold until every pending tick is transferred and every result is back,
    // then let the pipeline go quiet.
    task automatic settle();
        while (tick_pending.size() != 0 || drive_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reprogram all registers, slam every wheel to both rails, then run random ticks.
    // Halfway through, the sender stops until every owed result has arrived.
    task automatic run_phase(input int prop, input int integ, input int limit,
                             input int lowv, input int send_pct, input int recv_pct,
                             input int n_items, input bit hold);
        settle();
        write_reg(REG_PROP_GAIN, prop);
        write_reg(REG_INTEG_GAIN, integ);
        write_reg(REG_OUTPUT_LIMIT, limit);
        write_reg(REG_LOW_VOLTAGE, lowv);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        long_hold_req  = hold;
        tick_pending.push_back(make_tick(2047, 2047, 2047, -32768, -32768, -32768,
                                         65535, 1));
        tick_pending.push_back(make_tick(-2048, -2048, -2048, 32767, 32767, 32767,
                                         65535, 1));
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                settle();
            tick_pending.push_back(random_tick());
        end
        settle();
        long_hold_req = 1'b0;
    endtask

    // Driver: on a transfer, predict the result and drop the tick; present the
    // next tick only while the channel is free to change.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                drive_expected.push_back(advance_wheels(tick_pending.pop_front()));
            if (!in_valid || !in_stall)
            begin
                if (tick_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid      <= 1'b1;
                    speed_a       <= tick_pending[0].speed[0];
                    speed_b       <= tick_pending[0].speed[1];
                    speed_c       <= tick_pending[0].speed[2];
                    goal_a        <= tick_pending[0].goal[0];
                    goal_b        <= tick_pending[0].goal[1];
                    goal_c        <= tick_pending[0].goal[2];
                    battery_level <= tick_pending[0].battery;
                    drive_enable  <= tick_pending[0].enable;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction, and
    // drive the receiver stall, including one long hold-off per requested phase.
    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.duty     = {duty_c, duty_b, duty_a};
                got.reverse  = {reverse_c, reverse_b, reverse_a};
                got.shutdown = shutdown;
                if (drive_expected.size() == 0)
                begin
                    $error("drive result with no tick outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = drive_expected.pop_front();
                    for (int k = 0; k < 3; k++)
                    begin
                        if (got.duty[k] !== want.duty[k])
                        begin
                            $error("duty_%s expected %0d actual %0d", wheel_tag[k],
                                   want.duty[k], got.duty[k]);
                            mismatch_count++;
                        end
                        if (got.reverse[k] !== want.reverse[k])
                        begin
                            $error("reverse_%s expected %0d actual %0d", wheel_tag[k],
                                   want.reverse[k], got.reverse[k]);
                            mismatch_count++;
                        end
                    end
                    if (got.shutdown !== want.shutdown)
                    begin
                        $error("shutdown expected %0d actual %0d", want.shutdown,
                               got.shutdown);
                        mismatch_count++;
                    end
                end
            end
            if (long_hold_req && hold_count < LONG_HOLD_CYCLES)
            begin
                out_stall  <= 1'b1;
                hold_count <= hold_count + 1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
                if (!long_hold_req)
                    hold_count <= 0;
            end
        end
    end

    // Watchdog: too many cycles without any transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_three_wheel_incremental_pi_speed_loop: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under the reset register values
        tick_pending.push_back(make_tick(0, 0, 0, 0, 0, 0, 2000, 1));       // at threshold
        tick_pending.push_back(make_tick(100, -100, 5, 0, 0, 0, 1999, 1));  // just below
        tick_pending.push_back(make_tick(100, -100, 5, 0, 0, 0, 65535, 0)); // disabled
        tick_pending.push_back(make_tick(2047, 2047, 2047, -32768, -32768, -32768,
                                         65535, 1));                        // hit +rail
        tick_pending.push_back(make_tick(2047, 2047, 2047, -32768, -32768, -32768,
                                         65535, 1));
        tick_pending.push_back(make_tick(-2048, -2048, -2048, 32767, 32767, 32767,
                                         65535, 1));                        // hit -rail
        tick_pending.push_back(make_tick(-2048, -2048, -2048, 32767, 32767, 32767,
                                         65535, 1));
        tick_pending.push_back(make_tick(2047, -2048, 0, -32768, 32767, 0, 40000, 1));
        tick_pending.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 1));          // dead battery
        tick_pending.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
        tick_pending.push_back(make_tick(-2048, 2047, 7, 32767, -32768, 9, 65535, 0));
        tick_pending.push_back(make_tick(10, -10, 3, 12, -15, 3, 2500, 1)); // small errors
        tick_pending.push_back(make_tick(10, -10, 3, 12, -15, 3, 2500, 1));
        tick_pending.push_back(make_tick(-30, 40, 0, -20, 35, 1, 2001, 1));
        tick_pending.push_back(make_tick(5, 6, 7, 5, 6, 7, 2000, 1));       // zero error
        tick_pending.push_back(make_tick(0, 0, 0, 0, 0, 0, 2000, 1));

        // Output limit above the accumulator rail, high gains, no threshold
        run_phase(255, 255, 8191, 0, 0, 0, 180, 1'b0);
        // Zero output limit with maximum threshold; sender mostly idle
        run_phase(0, 1, 0, 65535, 81, 0, 160, 1'b0);
        // Limit at the rail, low gains; receiver mostly stalled
        run_phase(3, 7, ACCUM_LIMIT, 2000, 0, 81, 180, 1'b0);
        // Tight limit, both sides idling, with a long receiver hold-off
        run_phase(12, 2, 1000, 3000, 21, 21, 180, 1'b1);
        // Random settings; sender never idles while the receiver holds off
        run_phase($urandom_range(255), $urandom_range(255), $urandom_range(8191),
                  $urandom_range(4000), 0, 0, 200, 1'b1);
        // Back to the reset values, both sides idling
        run_phase(int'(PROP_GAIN_RST), int'(INTEG_GAIN_RST), int'(OUTPUT_LIMIT_RST),
                  int'(LOW_VOLTAGE_RST), 21, 21, 200, 1'b0);

        settle();
        if (mismatch_count == 0)
            $display("tb_three_wheel_incremental_pi_speed_loop: clean");
        else
            $display("tb_three_wheel_incremental_pi_speed_loop: errors");
        $finish;
    end

endmodule

/* three_wheel_incremental_pi_speed_loop.f */
rtl/twpi_pkg.sv
rtl/twpi_wheel.sv
rtl/three_wheel_incremental_pi_speed_loop.sv
dv/tb_three_wheel_incremental_pi_speed_loop.sv
